// ===== rtl/core/link_loss_watchdog_bank_core_defines.svh =====
// Assertion macros shared by the watchdog bank RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef LINK_LOSS_WATCHDOG_BANK_CORE_DEFINES_SVH
`define LINK_LOSS_WATCHDOG_BANK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLWB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("watchdog bank check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LLWB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("watchdog bank check failed");

`endif

// ===== rtl/core/llwb_pkg.sv =====
// Shared constants, codes and types of the watchdog bank.
// Used by every module of the block; depends on nothing.
package llwb_pkg;

    // Bank shape
    localparam int CHANNELS       = 8;
    localparam int FIRST_CRITICAL = 4;
    localparam int LINK_CHANNEL   = 0;

    // Field and storage widths
    localparam int NUM_PERIODS = 8;
    localparam int CFG_ADDR_W  = $clog2(NUM_PERIODS);
    localparam int PERIOD_W    = 14;
    localparam int COUNT_W     = 16;
    localparam int LIMIT_W     = 17;
    localparam int CH_IDX_W    = 3;
    localparam int MASK_W      = 8;
    localparam int WS_W        = 2;
    localparam int KEY_W       = 8;
    localparam int MOUSE_W     = 16;
    localparam int S_DATA_W    = 40;
    localparam int M_DATA_W    = 16;

    // Arithmetic constants
    localparam logic [COUNT_W-1:0]  COUNT_CEILING = 16'hFFFE;
    localparam logic [LIMIT_W-1:0]  LOST_FACTOR   = 17'd5;
    localparam logic signed [MOUSE_W-1:0] MOUSE_DEAD = 16'sd3;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 14'd10;

    // Item kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_FEED = 1'b1;

    // External work state codes; the unused code acts as other
    localparam logic [WS_W-1:0] WS_OTHER = 2'd0;
    localparam logic [WS_W-1:0] WS_CHECK = 2'd1;
    localparam logic [WS_W-1:0] WS_ERROR = 2'd2;

    typedef enum logic [1:0] {
        REQ_NONE    = 2'd0,
        REQ_ERROR   = 2'd1,
        REQ_LOST    = 2'd2,
        REQ_PROTECT = 2'd3
    } req_t;

    typedef logic [NUM_PERIODS-1:0][PERIOD_W-1:0] period_array_t;

    typedef struct packed {
        logic                       op;
        logic [CH_IDX_W-1:0]        channel;
        logic [WS_W-1:0]            work_state;
        logic [KEY_W-1:0]           key_high;
        logic [KEY_W-1:0]           key_low;
        logic signed [MOUSE_W-1:0]  mouse_dx;
    } item_t;

    typedef struct packed {
        logic                  armed;
        logic [MASK_W-1:0]     lost_mask;
        logic [CH_IDX_W-1:0]   fault_channel;
        req_t                  state_request;
    } result_t;

    // Mask of bits that belong to real channels
    localparam logic [MASK_W-1:0] CHANNEL_MASK = MASK_W'((1 << CHANNELS) - 1);

endpackage

// ===== rtl/core/llwb_count_bank.sv =====
// Silence counters of all channels and their lost evaluation on a tick.
// Depends on llwb_pkg.
module llwb_count_bank (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fire,
    input  llwb_pkg::item_t          item,
    input  llwb_pkg::period_array_t  period,
    output logic [llwb_pkg::MASK_W-1:0] tick_flags
);
    import llwb_pkg::*;

    logic [COUNT_W-1:0] count_reg  [CHANNELS];
    logic [COUNT_W-1:0] count_next [CHANNELS];
    logic [COUNT_W-1:0] count_inc  [CHANNELS];

    // Advance each counter with saturation and compare against five periods
    always_comb begin
        tick_flags = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            count_inc[i] = (count_reg[i] < COUNT_CEILING) ? count_reg[i] + 1'b1
                                                           : count_reg[i];
            tick_flags[i] = LIMIT_W'(count_inc[i]) >
                            (LIMIT_W'(period[i]) * LOST_FACTOR);
            count_next[i] = count_reg[i];
            if (fire) begin
                if (item.op == OP_TICK) begin
                    count_next[i] = count_inc[i];
                end else if (item.channel == CH_IDX_W'(i)) begin
                    count_next[i] = '0;
                end
            end
        end
    end

    // Hold the counters
    always_ff @(posedge aclk) begin
        for (int i = 0; i < CHANNELS; i++) begin
            if (!aresetn) begin
                count_reg[i] <= '0;
            end else begin
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

// ===== rtl/core/llwb_decide.sv =====
// Arm, fault record and lost flags, plus the state request of each word.
// Depends on llwb_pkg and the tick flags from llwb_count_bank.
module llwb_decide (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        fire,
    input  llwb_pkg::item_t             item,
    input  logic [llwb_pkg::MASK_W-1:0] tick_flags,
    output llwb_pkg::result_t           result_next
);
    import llwb_pkg::*;

    logic                armed_reg, armed_next;
    logic [CH_IDX_W-1:0] fault_reg, fault_next;
    logic [MASK_W-1:0]   lost_reg, lost_next;
    logic                err_hit;
    logic [WS_W-1:0]     eff_state;
    logic                activity;
    req_t                req;

    // Evaluate critical loss, link loss and remote activity
    always_comb begin
        armed_next = armed_reg;
        fault_next = fault_reg;
        lost_next  = lost_reg;
        err_hit    = 1'b0;
        req        = REQ_NONE;
        activity   = (item.key_high != '0) || (item.key_low != '0) ||
                     (item.mouse_dx > MOUSE_DEAD) || (item.mouse_dx < -MOUSE_DEAD);
        if (item.op == OP_TICK) begin
            lost_next = tick_flags;
            if (armed_reg) begin
                for (int i = FIRST_CRITICAL; i < CHANNELS; i++) begin
                    if (tick_flags[i]) begin
                        err_hit    = 1'b1;
                        fault_next = CH_IDX_W'(i);
                    end
                end
            end
            if (err_hit) begin
                req = REQ_ERROR;
            end
        end
        eff_state = err_hit ? WS_ERROR : item.work_state;
        if (item.op == OP_TICK) begin
            if (tick_flags[LINK_CHANNEL]) begin
                if (eff_state == WS_CHECK) begin
                    req = REQ_LOST;
                end else if (eff_state != WS_ERROR) begin
                    req = REQ_PROTECT;
                end
            end
            // Disarm after this tick's checks
            if (activity) begin
                armed_next = 1'b0;
            end
        end
        result_next.state_request = req;
        result_next.fault_channel = fault_next;
        result_next.lost_mask     = lost_next;
        result_next.armed         = armed_next;
    end

    // Hold the watchdog state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b1;
            fault_reg <= '0;
            lost_reg  <= '0;
        end else if (fire) begin
            armed_reg <= armed_next;
            fault_reg <= fault_next;
            lost_reg  <= lost_next;
        end
    end

endmodule

// ===== rtl/core/link_loss_watchdog_bank_core.sv =====
// A word waits in the input register; its result then sits in out_reg.
// Throughput: one word per cycle; while a result waits in the output
// register the input register takes at most one more word, then stalls.
// Reset (aresetn low, synchronous): counters, lost flags and fault record
// clear, the block arms, all periods return to 10 ticks.
// Top level of the watchdog bank; depends on llwb_pkg, llwb_count_bank,
// llwb_decide and the assertion macro header.
`include "link_loss_watchdog_bank_core_defines.svh"

module link_loss_watchdog_bank_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [llwb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [llwb_pkg::PERIOD_W-1:0]      cfg_wdata,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // channel[2:0], work_state[4:3], key_high[12:5], key_low[20:13],
    // mouse_dx[36:21], zero fill[39:37]
    input  logic [llwb_pkg::S_DATA_W-1:0]      s_tdata,
    // operation[0]
    input  logic                               s_tuser,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // state_request[1:0], fault_channel[4:2], lost_mask[12:5], armed[13],
    // zero fill[15:14]
    output logic [llwb_pkg::M_DATA_W-1:0]      m_tdata
);
    import llwb_pkg::*;

    period_array_t period_reg;
    logic          in_valid_reg, in_valid_next;
    item_t         in_item_reg;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg;
    logic          advance;
    logic          fire;
    logic          s_accept;
    logic [MASK_W-1:0] tick_flags;
    result_t       result_next;

    // Handshake between the input and output registers
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Hold flow control and period registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PERIODS; i++) begin
                period_reg[i] <= PERIOD_RESET;
            end
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                period_reg[cfg_addr] <= cfg_wdata;
            end
        end
    end

    // Capture the incoming word and the finished result
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.op         <= s_tuser;
            in_item_reg.channel    <= s_tdata[2:0];
            in_item_reg.work_state <= s_tdata[4:3];
            in_item_reg.key_high   <= s_tdata[12:5];
            in_item_reg.key_low    <= s_tdata[20:13];
            in_item_reg.mouse_dx   <= s_tdata[36:21];
        end
        if (fire) begin
            out_reg <= result_next;
        end
    end

    llwb_count_bank u_count_bank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (in_item_reg),
        .period     (period_reg),
        .tick_flags (tick_flags)
    );

    llwb_decide u_decide (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (in_item_reg),
        .tick_flags  (tick_flags),
        .result_next (result_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.armed, out_reg.lost_mask,
                       out_reg.fault_channel, out_reg.state_request};

    // Once disarmed, a result never shows the block armed again
    `LLWB_ASSERT_NEXT(a_disarm_sticks, aclk, aresetn,
        fire && !result_next.armed, !u_decide.armed_reg)
    // An error request names a channel that is lost in the same result
    `LLWB_ASSERT_NOW(a_error_has_fault, aclk, aresetn,
        m_tvalid && (out_reg.state_request == REQ_ERROR),
        out_reg.lost_mask[out_reg.fault_channel])
    // Lost bits never appear for channels beyond the bank
    `LLWB_ASSERT_NOW(a_mask_in_range, aclk, aresetn,
        m_tvalid, (out_reg.lost_mask & ~CHANNEL_MASK) == '0)
    // A feed word never raises a state request
    `LLWB_ASSERT_NEXT(a_feed_quiet, aclk, aresetn,
        fire && (in_item_reg.op == OP_FEED), out_reg.state_request == REQ_NONE)

endmodule

// ===== tb/sv/tb_link_loss_watchdog_bank_core.sv =====
// Self-checking bench for link_loss_watchdog_bank_core: directed and random feed/tick words,
// bursty sender, stalling receiver, in-order compare against a behavioral watchdog model.
// Depends on llwb_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_link_loss_watchdog_bank_core;
    import llwb_pkg::*;

    localparam logic [WS_W-1:0] WS_SPARE = 2'd3;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 14'd13107;
    localparam int RX_FREE = 0;
    localparam int RX_COIN = 1;
    localparam int RX_SLOW = 2;

    typedef struct {
        req_t                state_request;
        logic [CH_IDX_W-1:0] fault_channel;
        logic [MASK_W-1:0]   lost_mask;
        logic                armed;
    } verdict_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [PERIOD_W-1:0]   cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // Watchdog model state and its copy of the period registers
    logic [COUNT_W-1:0]  silence_cnt [CHANNELS];
    logic [PERIOD_W-1:0] period_cfg [NUM_PERIODS];
    logic [PERIOD_W-1:0] period_plan [NUM_PERIODS];
    logic [MASK_W-1:0]   lost_m;
    logic                armed_m;
    logic [CH_IDX_W-1:0] fault_m;

    verdict_t verdict_q [$];
    int burst_left = 0;
    int rx_mode = RX_FREE;
    int rx_span = 0;
    int feeds_sent = 0;
    int ticks_sent = 0;
    int words_checked = 0;
    int mismatches = 0;

    link_loss_watchdog_bank_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Advance the watchdog model by one word and return the result it produces
    function automatic verdict_t next_verdict(input item_t w);
        verdict_t v;
        logic [MASK_W-1:0] flags;
        logic [WS_W-1:0] eff;
        int mag;
        v.state_request = REQ_NONE;
        flags = '0;
        eff = w.work_state;
        mag = int'(w.mouse_dx);
        if (mag < 0) mag = -mag;
        if (w.op == OP_FEED) begin
            if (int'(w.channel) < CHANNELS) silence_cnt[w.channel] = '0;
        end else begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (silence_cnt[i] < COUNT_CEILING) silence_cnt[i] = silence_cnt[i] + 1'b1;
                if (int'(silence_cnt[i]) > int'(LOST_FACTOR) * int'(period_cfg[i]))
                    flags[i] = 1'b1;
            end
            lost_m = flags;
            // Critical losses win while armed; the highest channel is recorded
            if (armed_m) begin
                for (int i = FIRST_CRITICAL; i < CHANNELS; i++) begin
                    if (flags[i]) begin
                        fault_m = CH_IDX_W'(i);
                        v.state_request = REQ_ERROR;
                        eff = WS_ERROR;
                    end
                end
            end
            if (flags[LINK_CHANNEL]) begin
                if (eff == WS_CHECK) v.state_request = REQ_LOST;
                else if (eff != WS_ERROR) v.state_request = REQ_PROTECT;
            end
            // Remote activity disarms after this tick's checks
            if (w.key_high != '0 || w.key_low != '0 || mag > int'(MOUSE_DEAD)) armed_m = 1'b0;
        end
        v.fault_channel = fault_m;
        v.lost_mask = lost_m;
        v.armed = armed_m;
        return v;
    endfunction

    function automatic item_t make_word(input logic op, input int ch, input logic [WS_W-1:0] ws,
                                        input int kh, input int kl, input int mdx);
        item_t w;
        w.op = op;
        w.channel = CH_IDX_W'(ch);
        w.work_state = ws;
        w.key_high = KEY_W'(kh);
        w.key_low = KEY_W'(kl);
        w.mouse_dx = MOUSE_W'(mdx);
        return w;
    endfunction

    // Tick with no remote activity: keys idle, mouse inside the dead zone
    function automatic item_t quiet_tick();
        return make_word(OP_TICK, $urandom_range(0, 7), WS_W'($urandom_range(0, 3)), 0, 0,
                         int'($urandom_range(0, 6)) - 3);
    endfunction

    function automatic item_t noisy_tick();
        int mdx;
        mdx = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 65535))
                                          : int'($urandom_range(0, 10)) - 5;
        return make_word(OP_TICK, $urandom_range(0, 7), WS_W'($urandom_range(0, 3)),
                         ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : 0,
                         ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : 0, mdx);
    endfunction

    // Feeds ignore the remote fields, so fill them freely
    function automatic item_t any_feed();
        return make_word(OP_FEED, $urandom_range(0, 7), WS_W'($urandom_range(0, 3)),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         int'($urandom_range(0, 65535)));
    endfunction

    // Send one word; the sender runs in bursts separated by random gaps
    task automatic send_word(input item_t w);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 64);
        end
        s_tuser <= w.op;
        s_tdata <= {3'b000, w.mouse_dx, w.key_low, w.key_high, w.work_state, w.channel};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        verdict_q.push_back(next_verdict(w));
        burst_left--;
        if (w.op == OP_FEED) feeds_sent++;
        else ticks_sent++;
    endtask

    // Hold the input idle and wait for every expected word to come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write every period register from the plan, one per cycle
    task automatic load_periods();
        for (int i = 0; i < NUM_PERIODS; i++) begin
            cfg_we <= 1'b1;
            cfg_addr <= CFG_ADDR_W'(i);
            cfg_wdata <= period_plan[i];
            period_cfg[i] = period_plan[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic stream_mix(input int count, input int feed_pct, input bit noisy);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < feed_pct) send_word(any_feed());
            else if (noisy) send_word(noisy_tick());
            else send_word(quiet_tick());
        end
        drain_results();
    endtask

    // Link channel alone: lost in check, protect in other states, quiet in error
    task automatic test_link_requests();
        for (int i = 0; i < NUM_PERIODS; i++) period_plan[i] = PERIOD_MAX;
        period_plan[LINK_CHANNEL] = '0;
        load_periods();
        send_word(make_word(OP_FEED, LINK_CHANNEL, WS_CHECK, 0, 0, 0));
        send_word(make_word(OP_TICK, 0, WS_CHECK, 0, 0, 0));
        send_word(make_word(OP_TICK, 0, WS_OTHER, 0, 0, 3));
        send_word(make_word(OP_TICK, 0, WS_SPARE, 0, 0, -3));
        send_word(make_word(OP_TICK, 0, WS_ERROR, 0, 0, 0));
        send_word(make_word(OP_FEED, 7, WS_SPARE, 255, 255, 32767));
        send_word(make_word(OP_FEED, 0, WS_OTHER, 255, 255, -32768));
        send_word(make_word(OP_TICK, 7, WS_CHECK, 0, 0, 0));
        drain_results();
    endtask

    // Critical channels while armed, each time together with link loss
    task automatic test_critical_errors();
        period_plan[4] = '0;
        load_periods();
        send_word(make_word(OP_TICK, 0, WS_CHECK, 0, 0, 0));
        send_word(make_word(OP_TICK, 0, WS_OTHER, 0, 0, 0));
        send_word(make_word(OP_FEED, 4, WS_OTHER, 0, 0, 0));
        send_word(make_word(OP_FEED, LINK_CHANNEL, WS_OTHER, 0, 0, 0));
        period_plan[7] = '0;
        drain_results();
        load_periods();
        send_word(make_word(OP_TICK, 0, WS_SPARE, 0, 0, -3));
        send_word(make_word(OP_TICK, 0, WS_ERROR, 0, 0, 2));
        drain_results();
    endtask

    task automatic test_armed_random();
        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < NUM_PERIODS; i++) begin
                case (ph)
                    0: period_plan[i] = PERIOD_W'($urandom_range(0, 4));
                    1: period_plan[i] = (i >= FIRST_CRITICAL) ? PERIOD_MAX
                                                              : PERIOD_W'($urandom_range(0, 3));
                    2: period_plan[i] = '0;
                    default: period_plan[i] = (i == LINK_CHANNEL) ? PERIOD_MAX
                                                                  : PERIOD_W'($urandom_range(0, 6));
                endcase
            end
            load_periods();
            stream_mix(200, 45, 1'b0);
        end
    endtask

    // Activity disarms only after the tick that carries it
    task automatic test_disarm();
        for (int i = 0; i < NUM_PERIODS; i++) period_plan[i] = '0;
        load_periods();
        send_word(make_word(OP_TICK, 0, WS_CHECK, 0, 0, -4));
        send_word(make_word(OP_TICK, 0, WS_CHECK, 0, 0, 0));
        send_word(make_word(OP_TICK, 0, WS_ERROR, 1, 0, 4));
        send_word(make_word(OP_TICK, 0, WS_OTHER, 0, 128, -32768));
        send_word(make_word(OP_TICK, 0, WS_SPARE, 255, 255, 32767));
        send_word(make_word(OP_FEED, 3, WS_OTHER, 0, 0, 0));
        drain_results();
    endtask

    task automatic test_disarmed_random();
        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < NUM_PERIODS; i++) begin
                case (ph)
                    0: period_plan[i] = PERIOD_W'($urandom_range(0, 4));
                    1: period_plan[i] = (i == LINK_CHANNEL) ? '0 : PERIOD_MAX;
                    2: period_plan[i] = ($urandom_range(0, 1) == 1)
                                        ? PERIOD_W'($urandom_range(0, 13107))
                                        : PERIOD_W'($urandom_range(0, 2));
                    default: period_plan[i] = '0;
                endcase
            end
            load_periods();
            stream_mix(225, 45, 1'b1);
        end
    endtask

    // Walk every counter across its own lost threshold, then refeed one channel
    task automatic test_lost_threshold();
        for (int i = 0; i < NUM_PERIODS; i++) period_plan[i] = PERIOD_W'(24 + i);
        period_plan[5] = '0;
        load_periods();
        for (int i = 0; i < CHANNELS; i++) send_word(make_word(OP_FEED, i, WS_OTHER, 0, 0, 0));
        for (int n = 0; n < 160; n++) send_word(quiet_tick());
        send_word(make_word(OP_FEED, 1, WS_OTHER, 0, 0, 0));
        repeat (3) send_word(quiet_tick());
        drain_results();
    endtask

    // Receiver: pick a new stall pattern whenever the current span runs out
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_mode <= $urandom_range(RX_FREE, RX_SLOW);
            rx_span <= $urandom_range(50, 400);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            RX_FREE: m_tready <= 1'b1;
            RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare each returned word with the oldest expected one
    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
            end else begin
                v = verdict_q.pop_front();
                words_checked++;
                check_field("state_request", int'(v.state_request), int'(m_tdata[1:0]));
                check_field("fault_channel", int'(v.fault_channel), int'(m_tdata[4:2]));
                check_field("lost_mask", int'(v.lost_mask), int'(m_tdata[12:5]));
                check_field("armed", int'(v.armed), int'(m_tdata[13]));
            end
        end
    end

    initial begin
        for (int i = 0; i < CHANNELS; i++) silence_cnt[i] = '0;
        for (int i = 0; i < NUM_PERIODS; i++) period_cfg[i] = PERIOD_RESET;
        lost_m = '0;
        armed_m = 1'b1;
        fault_m = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_link_requests();
        test_critical_errors();
        test_armed_random();
        test_disarm();
        test_disarmed_random();
        test_lost_threshold();

        repeat (8) @(posedge aclk);
        $display("Covered %0d feeds and %0d ticks: link and critical requests, disarm,",
                 feeds_sent, ticks_sent);
        $display("random armed/disarmed mixes and lost thresholds; %0d words compared.",
                 words_checked);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("tb_link_loss_watchdog_bank_core passed");
        end else begin
            $display("tb_link_loss_watchdog_bank_core failed");
        end
        $finish;
    end

    // Hard stop for a hung handshake
    initial begin
        #20000000;
        $display("tb_link_loss_watchdog_bank_core failed");
        $finish;
    end

endmodule

// ===== link_loss_watchdog_bank_core.f =====
+incdir+rtl/core
rtl/core/llwb_pkg.sv
rtl/core/llwb_count_bank.sv
rtl/core/llwb_decide.sv
rtl/core/link_loss_watchdog_bank_core.sv
tb/sv/tb_link_loss_watchdog_bank_core.sv
